>>> rtl/ods_pkg.sv
package ods_pkg;

  localparam int CoefWidthDefault = 32;
  localparam int DetWidth = 66;
  localparam int QuotWidth = 49;

  localparam logic [1:0] KIND_UNIQUE = 2'd0;
  localparam logic [1:0] KIND_INF = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [1:0] REG_DET_TOL = 2'd0;
  localparam logic [1:0] REG_SOL_TOL = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic sat;
  } ods_pair_t;

endpackage

>>> rtl/ods_if.sv
interface ods_in_if;
  logic valid;
  logic ready;
  logic [31:0] eq1_coef_u;
  logic [31:0] eq1_coef_v;
  logic [31:0] eq1_rhs;
  logic [31:0] eq2_coef_u;
  logic [31:0] eq2_coef_v;
  logic [31:0] eq2_rhs;
  logic [31:0] eq3_coef_u;
  logic [31:0] eq3_coef_v;
  logic [31:0] eq3_rhs;
  modport source (output valid, eq1_coef_u, eq1_coef_v, eq1_rhs, eq2_coef_u, eq2_coef_v,
                  eq2_rhs, eq3_coef_u, eq3_coef_v, eq3_rhs, input ready);
  modport sink (input valid, eq1_coef_u, eq1_coef_v, eq1_rhs, eq2_coef_u, eq2_coef_v,
                eq2_rhs, eq3_coef_u, eq3_coef_v, eq3_rhs, output ready);
endinterface

interface ods_out_if;
  logic valid;
  logic ready;
  logic [1:0] outcome;
  logic [31:0] sol_u;
  logic [31:0] sol_v;
  logic saturated;
  modport source (output valid, outcome, sol_u, sol_v, saturated, input ready);
  modport sink (input valid, outcome, sol_u, sol_v, saturated, output ready);
endinterface

>>> rtl/ods_pair.sv
module ods_pair
  import ods_pkg::*;
#(
  parameter int COEF_WIDTH = CoefWidthDefault
) (
  input  logic clk,
  input  logic en,
  input  logic [31:0] det_tol,
  input  logic signed [COEF_WIDTH-1:0] a1,
  input  logic signed [COEF_WIDTH-1:0] b1,
  input  logic signed [COEF_WIDTH-1:0] c1,
  input  logic signed [COEF_WIDTH-1:0] a2,
  input  logic signed [COEF_WIDTH-1:0] b2,
  input  logic signed [COEF_WIDTH-1:0] c2,
  output ods_pair_t res
);
  // Stage 1: six products. Stage 2: determinants. Stage 3: classify and
  // magnitudes. Then one divider setup stage and QuotWidth restoring
  // division stages, one quotient bit per stage, and a saturation register.
  localparam int PW = 2 * COEF_WIDTH;
  localparam int NSTEP = QuotWidth;

  logic signed [PW-1:0] m_a1b2, m_a2b1, m_c1b2, m_c2b1, m_a1c2, m_a2c1;
  logic signed [DetWidth-1:0] dm, du, dv;
  logic [DetWidth-1:0] tol_ext;
  logic singular, kind_inf;
  logic [1:0] kind_s3;
  logic [DetWidth-1:0] mag_m, mag_u, mag_v;
  logic neg_u, neg_v;

  function automatic logic [DetWidth-1:0] mag(input logic signed [DetWidth-1:0] x);
    mag = x[DetWidth-1] ? DetWidth'(-x) : x;
  endfunction

  function automatic logic near0(input logic signed [DetWidth-1:0] x,
                                 input logic [DetWidth-1:0] t);
    near0 = (x == '0) || (mag(x) < t);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m_a1b2 <= PW'(a1 * b2);
      m_a2b1 <= PW'(a2 * b1);
      m_c1b2 <= PW'(c1 * b2);
      m_c2b1 <= PW'(c2 * b1);
      m_a1c2 <= PW'(a1 * c2);
      m_a2c1 <= PW'(a2 * c1);
      dm <= DetWidth'(m_a1b2) - DetWidth'(m_a2b1);
      du <= DetWidth'(m_c1b2) - DetWidth'(m_c2b1);
      dv <= DetWidth'(m_a1c2) - DetWidth'(m_a2c1);
      mag_m <= mag(dm);
      mag_u <= mag(du);
      mag_v <= mag(dv);
      neg_u <= du[DetWidth-1] != dm[DetWidth-1];
      neg_v <= dv[DetWidth-1] != dm[DetWidth-1];
      kind_s3 <= singular ? (kind_inf ? KIND_INF : KIND_NONE) : KIND_UNIQUE;
    end
  end

  assign tol_ext = DetWidth'(det_tol);
  assign singular = near0(dm, tol_ext);
  assign kind_inf = near0(du, tol_ext) && near0(dv, tol_ext);

  // Long division of n<<16 by d, producing NSTEP quotient bits; the
  // partial remainder stays below d so DetWidth+1 bits are enough.
  localparam int RW = DetWidth + 1;
  logic [RW-1:0] ru [NSTEP+1];
  logic [RW-1:0] rv [NSTEP+1];
  logic [QuotWidth-1:0] nu [NSTEP+1];
  logic [QuotWidth-1:0] nv [NSTEP+1];
  logic [QuotWidth-1:0] qu [NSTEP+1];
  logic [QuotWidth-1:0] qv [NSTEP+1];
  logic [DetWidth-1:0] dd [NSTEP+1];
  logic [1:0] kd [NSTEP+1];
  logic nsu [NSTEP+1];
  logic nsv [NSTEP+1];
  logic ovu [NSTEP+1];
  logic ovv [NSTEP+1];

  // Quotient of a Q32.32 by Q32.32 in Q16.16 is (n<<16)/d; n<<16 is 82 bits.
  localparam int NW = DetWidth + 16;
  logic [NW-1:0] sh_u, sh_v;
  assign sh_u = {mag_u, 16'd0};
  assign sh_v = {mag_v, 16'd0};

  // Bits above the top QuotWidth quotient bits: quotient overflows if the
  // high part of the dividend is at least d (quotient >= 2^QuotWidth).
  logic [RW-1:0] hi_u, hi_v;
  assign hi_u = RW'(sh_u[NW-1:QuotWidth]);
  assign hi_v = RW'(sh_v[NW-1:QuotWidth]);

  always_ff @(posedge clk) begin
    if (en) begin
      ovu[0] <= hi_u >= RW'(mag_m);
      ovv[0] <= hi_v >= RW'(mag_m);
      ru[0] <= (hi_u >= RW'(mag_m)) ? '0 : hi_u;
      rv[0] <= (hi_v >= RW'(mag_m)) ? '0 : hi_v;
      nu[0] <= sh_u[QuotWidth-1:0];
      nv[0] <= sh_v[QuotWidth-1:0];
      qu[0] <= '0;
      qv[0] <= '0;
      dd[0] <= mag_m;
      kd[0] <= kind_s3;
      nsu[0] <= neg_u;
      nsv[0] <= neg_v;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_div
    logic [RW-1:0] tu, tv;
    assign tu = {ru[i][RW-2:0], nu[i][QuotWidth-1-i]};
    assign tv = {rv[i][RW-2:0], nv[i][QuotWidth-1-i]};
    always_ff @(posedge clk) begin
      if (en) begin
        ru[i+1] <= (tu >= RW'(dd[i])) ? tu - RW'(dd[i]) : tu;
        rv[i+1] <= (tv >= RW'(dd[i])) ? tv - RW'(dd[i]) : tv;
        qu[i+1] <= {qu[i][QuotWidth-2:0], tu >= RW'(dd[i])};
        qv[i+1] <= {qv[i][QuotWidth-2:0], tv >= RW'(dd[i])};
        nu[i+1] <= nu[i];
        nv[i+1] <= nv[i];
        dd[i+1] <= dd[i];
        kd[i+1] <= kd[i];
        nsu[i+1] <= nsu[i];
        nsv[i+1] <= nsv[i];
        ovu[i+1] <= ovu[i];
        ovv[i+1] <= ovv[i];
      end
    end
  end

  logic signed [31:0] fu, fv;
  logic su, sv;

  always_comb begin
    logic [QuotWidth-1:0] q;
    q = qu[NSTEP];
    su = 1'b0;
    if (nsu[NSTEP]) begin
      if (ovu[NSTEP] || q > QuotWidth'(33'h080000000)) begin
        su = 1'b1;
        fu = 32'sh80000000;
      end else begin
        fu = 32'(-q);
      end
    end else if (ovu[NSTEP] || q > QuotWidth'(33'h07FFFFFFF)) begin
      su = 1'b1;
      fu = 32'sh7FFFFFFF;
    end else begin
      fu = 32'(q);
    end
    q = qv[NSTEP];
    sv = 1'b0;
    if (nsv[NSTEP]) begin
      if (ovv[NSTEP] || q > QuotWidth'(33'h080000000)) begin
        sv = 1'b1;
        fv = 32'sh80000000;
      end else begin
        fv = 32'(-q);
      end
    end else if (ovv[NSTEP] || q > QuotWidth'(33'h07FFFFFFF)) begin
      sv = 1'b1;
      fv = 32'sh7FFFFFFF;
    end else begin
      fv = 32'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.kind <= kd[NSTEP];
      res.u <= (kd[NSTEP] == KIND_UNIQUE) ? fu : '0;
      res.v <= (kd[NSTEP] == KIND_UNIQUE) ? fv : '0;
      res.sat <= (kd[NSTEP] == KIND_UNIQUE) && (su || sv);
    end
  end

endmodule

>>> rtl/overdetermined_2var_system_solver.sv
// Stages from an accepted item to its result: 3 arithmetic stages, a divider
// setup stage, QuotWidth stages of the bit-per-stage divider, 1 output register,
// 1 combining stage. Throughput: one item per cycle; the pipeline only holds
// when the output item is not taken.
// Reset: rst is synchronous and active high; it clears all valid bits and
// loads the tolerance registers with 4096 and 16.
module overdetermined_2var_system_solver
  import ods_pkg::*;
#(
  parameter int COEF_WIDTH = CoefWidthDefault
) (
  input  logic clk,
  input  logic rst,
  ods_in_if.sink  in_ch,
  ods_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  // Each pair unit runs products, determinants, classification, a divider
  // setup stage, QuotWidth divider stages and a saturation register; the
  // top adds one combining stage.
  localparam int PAIR_LAT = QuotWidth + 5;
  localparam int LAT = PAIR_LAT + 1;

  logic [31:0] det_tol;
  logic [15:0] sol_tol;
  logic [1:0] reg_idx;
  logic en;
  logic [LAT-1:0] vpipe;

  assign pready = 1'b1;
  assign reg_idx = paddr[2] ? REG_SOL_TOL : REG_DET_TOL;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_tol <= 32'd4096;
      sol_tol <= 16'd16;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      unique case (reg_idx)
        REG_DET_TOL: det_tol <= pwdata;
        REG_SOL_TOL: sol_tol <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DET_TOL: prdata = det_tol;
      REG_SOL_TOL: prdata = {16'd0, sol_tol};
      default: prdata = '0;
    endcase
  end

  // The whole pipeline advances together; it stalls only when the final
  // register holds a result that the consumer has not taken.
  assign en = !vpipe[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_ch.valid};
    end
  end

  ods_pair_t p12, p23, p13;

  ods_pair #(.COEF_WIDTH(COEF_WIDTH)) u_p12 (
    .clk(clk), .en(en), .det_tol(det_tol),
    .a1(in_ch.eq1_coef_u[COEF_WIDTH-1:0]), .b1(in_ch.eq1_coef_v[COEF_WIDTH-1:0]),
    .c1(in_ch.eq1_rhs[COEF_WIDTH-1:0]),
    .a2(in_ch.eq2_coef_u[COEF_WIDTH-1:0]), .b2(in_ch.eq2_coef_v[COEF_WIDTH-1:0]),
    .c2(in_ch.eq2_rhs[COEF_WIDTH-1:0]), .res(p12));

  ods_pair #(.COEF_WIDTH(COEF_WIDTH)) u_p23 (
    .clk(clk), .en(en), .det_tol(det_tol),
    .a1(in_ch.eq2_coef_u[COEF_WIDTH-1:0]), .b1(in_ch.eq2_coef_v[COEF_WIDTH-1:0]),
    .c1(in_ch.eq2_rhs[COEF_WIDTH-1:0]),
    .a2(in_ch.eq3_coef_u[COEF_WIDTH-1:0]), .b2(in_ch.eq3_coef_v[COEF_WIDTH-1:0]),
    .c2(in_ch.eq3_rhs[COEF_WIDTH-1:0]), .res(p23));

  ods_pair #(.COEF_WIDTH(COEF_WIDTH)) u_p13 (
    .clk(clk), .en(en), .det_tol(det_tol),
    .a1(in_ch.eq1_coef_u[COEF_WIDTH-1:0]), .b1(in_ch.eq1_coef_v[COEF_WIDTH-1:0]),
    .c1(in_ch.eq1_rhs[COEF_WIDTH-1:0]),
    .a2(in_ch.eq3_coef_u[COEF_WIDTH-1:0]), .b2(in_ch.eq3_coef_v[COEF_WIDTH-1:0]),
    .c2(in_ch.eq3_rhs[COEF_WIDTH-1:0]), .res(p13));

  // Coordinates agree when the magnitude of their 33-bit difference is below the tolerance.
  function automatic logic close(input logic signed [31:0] a, input logic signed [31:0] b,
                                 input logic [15:0] t);
    logic signed [32:0] d;
    logic [32:0] m;
    d = 33'(a) - 33'(b);
    m = d[32] ? 33'(-d) : d;
    close = m < 33'(t);
  endfunction

  logic i12, i23, i13, agree;
  ods_pair_t r;

  assign i12 = p12.kind == KIND_INF;
  assign i23 = p23.kind == KIND_INF;
  assign i13 = p13.kind == KIND_INF;
  assign agree = p12.kind == KIND_UNIQUE && p23.kind == KIND_UNIQUE &&
                 p13.kind == KIND_UNIQUE &&
                 close(p12.u, p13.u, sol_tol) && close(p12.v, p13.v, sol_tol) &&
                 close(p12.u, p23.u, sol_tol) && close(p12.v, p23.v, sol_tol);

  // Fixed pair priority: an infinite pair hands the choice to another pair, unless all three are infinite.
  always_comb begin
    if (i12 && i23 && i13) r = p12;
    else if (i12 && i23) r = p13;
    else if (i12 && i13) r = p23;
    else if (i23 && i13) r = p12;
    else if (i12) r = p23;
    else if (i23) r = p13;
    else if (i13) r = p12;
    else if (agree) r = p12;
    else r = '{kind: KIND_NONE, u: '0, v: '0, sat: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.outcome <= r.kind;
      out_ch.sol_u <= r.u;
      out_ch.sol_v <= r.v;
      out_ch.saturated <= r.sat;
    end
  end

  assign out_ch.valid = vpipe[LAT-1];

endmodule

>>> tb/tb_overdetermined_2var_system_solver.sv
`timescale 1ns / 1ps

module tb_overdetermined_2var_system_solver;
  import ods_pkg::*;

  // One system of three equations; row k holds coef_u, coef_v and rhs of equation k+1.
  typedef struct {
    int eq [3][3];
  } system_t;

  // The combined answer for one system, at the widths of the output item.
  typedef struct {
    logic [1:0]  outcome;
    logic [31:0] sol_u;
    logic [31:0] sol_v;
    logic        saturated;
  } answer_t;

  // Solution of one pair of equations, coordinates kept as saturated Q16.16.
  typedef struct {
    logic [1:0] kind;
    longint     u;
    longint     v;
    logic       sat;
  } pair_sol_t;

  // The scoreboard keeps its own copy of the tolerances and predicts the answer of every
  // accepted system by Cramer's rule, then matches output items in order.
  class solver_board;
    logic [63:0] det_tol = 64'd4096;
    logic [63:0] sol_tol = 64'd16;
    answer_t     answers [$];
    int          errors = 0;

    function logic [63:0] magnitude(longint x);
      logic [63:0] m;
      m = x;
      if (x < 0) begin
        m = -m;
      end
      return m;
    endfunction

    function bit near_zero(longint d);
      return (d == 0) || (magnitude(d) < det_tol);
    endfunction

    // Q32.32 over Q32.32 gives Q16.16, truncated toward zero and clamped.
    function longint divide(longint num, longint den, ref logic sat);
      logic [79:0] q;
      bit neg;
      q = {magnitude(num), 16'h0} / {16'h0, magnitude(den)};
      neg = (num < 0) != (den < 0);
      if (neg) begin
        if (q > 80'h8000_0000) begin
          sat = 1'b1;
          return -longint'(64'h8000_0000);
        end
        return -longint'(q[63:0]);
      end
      if (q > 80'h7FFF_FFFF) begin
        sat = 1'b1;
        return longint'(64'h7FFF_FFFF);
      end
      return longint'(q[63:0]);
    endfunction

    function pair_sol_t solve_pair(int e1 [3], int e2 [3]);
      pair_sol_t p;
      longint dm, du, dv;
      dm = longint'(e1[0]) * e2[1] - longint'(e2[0]) * e1[1];
      du = longint'(e1[2]) * e2[1] - longint'(e2[2]) * e1[1];
      dv = longint'(e1[0]) * e2[2] - longint'(e2[0]) * e1[2];
      p.u = 0;
      p.v = 0;
      p.sat = 1'b0;
      if (near_zero(dm)) begin
        p.kind = (near_zero(du) && near_zero(dv)) ? KIND_INF : KIND_NONE;
        return p;
      end
      p.kind = KIND_UNIQUE;
      p.u = divide(du, dm, p.sat);
      p.v = divide(dv, dm, p.sat);
      return p;
    endfunction

    function bit agree(pair_sol_t a, pair_sol_t b);
      return a.kind == KIND_UNIQUE && b.kind == KIND_UNIQUE &&
             magnitude(a.u - b.u) < sol_tol && magnitude(a.v - b.v) < sol_tol;
    endfunction

    function void note(system_t s);
      pair_sol_t p12, p23, p13, r;
      bit i12, i23, i13;
      answer_t a;
      p12 = solve_pair(s.eq[0], s.eq[1]);
      p23 = solve_pair(s.eq[1], s.eq[2]);
      p13 = solve_pair(s.eq[0], s.eq[2]);
      i12 = p12.kind == KIND_INF;
      i23 = p23.kind == KIND_INF;
      i13 = p13.kind == KIND_INF;
      // A fixed priority picks which pair speaks when some pairs are degenerate.
      if (i12 && i23 && i13) r = p12;
      else if (i12 && i23) r = p13;
      else if (i12 && i13) r = p23;
      else if (i23 && i13) r = p12;
      else if (i12) r = p23;
      else if (i23) r = p13;
      else if (i13) r = p12;
      else if (agree(p12, p13) && agree(p12, p23)) r = p12;
      else r.kind = KIND_NONE;
      a.outcome = r.kind;
      a.sol_u = (r.kind == KIND_UNIQUE) ? r.u[31:0] : 32'h0;
      a.sol_v = (r.kind == KIND_UNIQUE) ? r.v[31:0] : 32'h0;
      a.saturated = (r.kind == KIND_UNIQUE) ? r.sat : 1'b0;
      answers.push_back(a);
    endfunction

    function void check(answer_t got);
      answer_t want;
      if (answers.size() == 0) begin
        $error("output item with no system pending");
        errors++;
        return;
      end
      want = answers.pop_front();
      if (got.outcome !== want.outcome) begin
        $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
        errors++;
      end
      if (got.sol_u !== want.sol_u) begin
        $error("sol_u: expected %h, actual %h", want.sol_u, got.sol_u);
        errors++;
      end
      if (got.sol_v !== want.sol_v) begin
        $error("sol_v: expected %h, actual %h", want.sol_v, got.sol_v);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ods_in_if  in_ch ();
  ods_out_if out_ch ();

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle = 0;
  int recv_stall = 0;

  solver_board board = new();

  overdetermined_2var_system_solver i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #6 clk = ~clk;

  // The receiver checks every output item taken at this edge, then decides whether it
  // stalls in the next cycle.
  always @(posedge clk) begin
    answer_t got;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.outcome = out_ch.outcome;
        got.sol_u = out_ch.sol_u;
        got.sol_v = out_ch.sol_v;
        got.saturated = out_ch.saturated;
        board.check(got);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Register writes go through a setup and an access cycle; the register takes the value
  // at the edge that ends the access cycle, and the scoreboard follows it there.
  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 1'b0} << 1;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_DET_TOL) begin
      board.det_tol = 64'(value);
    end else begin
      board.sol_tol = 64'(value[15:0]);
    end
  endtask

  // Called in the time step of a rising edge; returns in the step of the accepting edge,
  // or after a random gap with valid low; the caller may then present the next item.
  task automatic send_system(system_t s);
    in_ch.valid <= 1'b1;
    in_ch.eq1_coef_u <= s.eq[0][0];
    in_ch.eq1_coef_v <= s.eq[0][1];
    in_ch.eq1_rhs <= s.eq[0][2];
    in_ch.eq2_coef_u <= s.eq[1][0];
    in_ch.eq2_coef_v <= s.eq[1][1];
    in_ch.eq2_rhs <= s.eq[1][2];
    in_ch.eq3_coef_u <= s.eq[2][0];
    in_ch.eq3_coef_v <= s.eq[2][1];
    in_ch.eq3_rhs <= s.eq[2][2];
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    board.note(s);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle);
    end
  endtask

  // Equation with small integer coefficients that holds exactly at (u, v).
  function automatic void exact_eq(ref int e [3], input int u, input int v);
    int a, b;
    a = $urandom_range(16) - 8;
    b = $urandom_range(16) - 8;
    e[0] = a <<< 16;
    e[1] = b <<< 16;
    e[2] = (a * u + b * v) <<< 16;
  endfunction

  // Most systems are well formed so that every pair outcome and the agreement test are
  // reached; the rest is raw noise over the full range of every field.
  function automatic system_t random_system();
    system_t s;
    int u, v, kind, k;
    u = $urandom_range(200) - 100;
    v = $urandom_range(200) - 100;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      exact_eq(s.eq[i], u, v);
    end
    if (kind < 15) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s.eq[i][j] = $urandom;
        end
      end
    end else if (kind < 45) begin
      // Consistent system, sometimes nudged by a few LSBs to probe the agreement window.
      if ($urandom_range(2) == 0) begin
        s.eq[$urandom_range(2)][2] += $urandom_range(64) - 32;
      end
    end else if (kind < 60) begin
      // One equation is a multiple of another: that pair is degenerate.
      k = $urandom_range(4) - 2;
      if (k == 0) k = 3;
      s.eq[1][0] = s.eq[0][0] * k;
      s.eq[1][1] = s.eq[0][1] * k;
      s.eq[1][2] = s.eq[0][2] * k;
    end else if (kind < 72) begin
      // Parallel equations with a different right-hand side.
      s.eq[2][0] = s.eq[$urandom_range(1)][0];
      s.eq[2][1] = s.eq[0][1];
      s.eq[2][0] = s.eq[0][0];
      s.eq[2][2] = s.eq[0][2] + ($urandom_range(5) + 1) * 65536;
    end else if (kind < 82) begin
      // All three equations describe the same line.
      for (int i = 1; i < 3; i++) begin
        k = $urandom_range(3) + 1;
        s.eq[i][0] = s.eq[0][0] * k;
        s.eq[i][1] = s.eq[0][1] * k;
        s.eq[i][2] = s.eq[0][2] * k;
      end
    end else if (kind < 92) begin
      // Tiny determinants against large right-hand sides, to hit the tolerance and clamp.
      for (int i = 0; i < 3; i++) begin
        s.eq[i][0] = $urandom_range(255) - 128;
        s.eq[i][1] = $urandom_range(255) - 128;
        s.eq[i][2] = $urandom;
      end
    end else begin
      // Random content with one equation reused, mixing noise and degeneracy.
      for (int j = 0; j < 3; j++) begin
        s.eq[0][j] = $urandom;
        s.eq[1][j] = $urandom;
      end
      s.eq[2] = s.eq[$urandom_range(1)];
    end
    return s;
  endfunction

  function automatic system_t fill_system(int a, int b, int c);
    system_t s;
    for (int i = 0; i < 3; i++) begin
      s.eq[i][0] = a;
      s.eq[i][1] = b;
      s.eq[i][2] = c;
    end
    return s;
  endfunction

  task automatic run_directed();
    system_t s;
    int max_val, min_val;
    max_val = 32'h7FFF_FFFF;
    min_val = 32'h8000_0000;
    // All zero: every pair is degenerate and consistent.
    send_system(fill_system(0, 0, 0));
    // Identical lines at the extremes of the fields.
    send_system(fill_system(max_val, max_val, max_val));
    send_system(fill_system(min_val, min_val, min_val));
    send_system(fill_system(min_val, max_val, -1));
    // Exact unique solution u = 3, v = -2.
    s.eq[0] = '{1 <<< 16, 1 <<< 16, 1 <<< 16};
    s.eq[1] = '{1 <<< 16, -1 <<< 16, 5 <<< 16};
    s.eq[2] = '{2 <<< 16, 1 <<< 16, 4 <<< 16};
    send_system(s);
    // Third equation disagrees: no common solution.
    s.eq[2][2] = 7 <<< 16;
    send_system(s);
    // Equations one and two coincide, so pair (2,3) is returned.
    s.eq[1] = s.eq[0];
    send_system(s);
    // Equations two and three coincide, so pair (1,3) is returned.
    s.eq[1] = '{1 <<< 16, -1 <<< 16, 5 <<< 16};
    s.eq[2] = s.eq[1];
    send_system(s);
    // Equations one and three coincide, so pair (1,2) is returned.
    s.eq[2] = s.eq[0];
    send_system(s);
    // Every pair is degenerate: lines one and two coincide with three parallel to them.
    s.eq[1] = s.eq[0];
    s.eq[2] = '{1 <<< 16, 1 <<< 16, 9 <<< 16};
    send_system(s);
    // Parallel pair returned by the priority, giving no solution.
    s.eq[0] = '{1 <<< 16, 2 <<< 16, 3 <<< 16};
    s.eq[1] = '{1 <<< 16, 2 <<< 16, 4 <<< 16};
    s.eq[2] = s.eq[1];
    send_system(s);
    // Determinant of one LSB with a huge numerator: clamps once the tolerance is low.
    s.eq[0] = '{1, 0, max_val};
    s.eq[1] = '{0, 1, min_val};
    s.eq[2] = '{1, 1, 0};
    send_system(s);
    s.eq[0] = '{max_val, 0, min_val};
    s.eq[1] = '{0, min_val, max_val};
    s.eq[2] = '{max_val, min_val, 0};
    send_system(s);
    s.eq[0] = '{min_val, min_val, min_val};
    s.eq[1] = '{max_val, min_val, max_val};
    s.eq[2] = '{min_val, max_val, min_val};
    send_system(s);
    s.eq[0] = '{-1, -1, -1};
    s.eq[1] = '{-1, 1, 1};
    s.eq[2] = '{1, -1, -1};
    send_system(s);
  endtask

  task automatic drain();
    while (board.answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int send_pct [4];
    int stall_pct [4];
    logic [31:0] det_set [4];
    logic [31:0] sol_set [4];
    send_pct = '{0, 86, 0, 19};
    stall_pct = '{0, 0, 86, 19};
    det_set = '{32'd4096, 32'd0, 32'hFFFF_FFFF, 32'd0};
    sol_set = '{32'd16, 32'd0, 32'h0000_FFFF, 32'd0};
    det_set[3] = $urandom_range(65535);
    sol_set[3] = $urandom_range(255);

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.eq1_coef_u <= '0;
    in_ch.eq1_coef_v <= '0;
    in_ch.eq1_rhs <= '0;
    in_ch.eq2_coef_u <= '0;
    in_ch.eq2_coef_v <= '0;
    in_ch.eq2_rhs <= '0;
    in_ch.eq3_coef_u <= '0;
    in_ch.eq3_coef_v <= '0;
    in_ch.eq3_rhs <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The directed systems run at the reset tolerances and again with both at zero,
    // where only exactly zero determinants count as singular.
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_DET_TOL, det_set[p]);
      write_reg(REG_SOL_TOL, sol_set[p]);
      send_idle = send_pct[p];
      recv_stall = stall_pct[p];
      @(posedge clk);
      if (p < 2) begin
        run_directed();
      end
      for (int n = 0; n < 160; n++) begin
        send_system(random_system());
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    if (board.errors == 0) begin
      $display("overdetermined_2var_system_solver verification clean");
    end else begin
      $display("overdetermined_2var_system_solver verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("overdetermined_2var_system_solver verification failed");
    $finish;
  end

endmodule
